FILE: src/p8rc_pkg.sv
// Shared types, widths and constants of the 8-bit PCM rate converter.
// No dependencies; all other files but p8rc_divider import this package.
package p8rc_pkg;

    // Fixed-point format of the rate registers and the window arithmetic.
    localparam int FRAC_BITS = 16;

    localparam int STEP_W    = 21;
    localparam int RECIP_W   = 17;
    localparam int ALIGN_W   = 6;
    localparam int CFG_W     = STEP_W;
    localparam int CFG_IDX_W = 2;
    localparam int SAMPLE_W  = 8;

    localparam int SUM_W    = 30;
    localparam int PHASE_W  = 22;
    localparam int LV_W     = SAMPLE_W + FRAC_BITS;
    localparam int CNT_W    = 5;
    localparam int BUDGET_W = FRAC_BITS + 1;
    localparam int PROD_W   = SUM_W + RECIP_W + 1;

    localparam logic [BUDGET_W-1:0] Q_ONE = BUDGET_W'(1) << FRAC_BITS;
    localparam logic [SAMPLE_W-1:0] SAMPLE_BIAS = 8'h80;

    // Window product limits: 127.0 and -128.0 in Q(2*FRAC_BITS).
    localparam logic signed [PROD_W-1:0] P_HI = PROD_W'(127) << (2 * FRAC_BITS);
    localparam logic signed [PROD_W-1:0] P_LO = -(PROD_W'(128) << (2 * FRAC_BITS));

    localparam logic [STEP_W-1:0]  DEF_STEP_RATIO = STEP_W'(Q_ONE);
    localparam logic [RECIP_W-1:0] DEF_STEP_RECIP = RECIP_W'(Q_ONE);
    localparam logic [ALIGN_W-1:0] DEF_ALIGN      = ALIGN_W'(1);

    localparam int DEF_MAX_ALIGN    = 32;
    localparam int DEF_MAX_UPSAMPLE = 32;
    localparam int QUEUE_DEPTH      = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_RATIO = 2'd0,
        REG_STEP_RECIP = 2'd1,
        REG_ALIGN      = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [STEP_W-1:0]  step_ratio;
        logic [RECIP_W-1:0] step_recip;
        logic [ALIGN_W-1:0] align;
    } t_cfg;

    // One classified input sample as it waits in the queue.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic                       avg;
        logic                       pad_en;
        logic [ALIGN_W-1:0]         pad_a;
    } t_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG,
        ST_MUL,
        ST_EMIT,
        ST_REP,
        ST_FINISH,
        ST_PAD_SETUP,
        ST_PAD_MUL,
        ST_PAD_DIV,
        ST_PAD_PUT,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        RET_AVG,
        RET_FINISH,
        RET_PAD
    } t_ret;

endpackage

FILE: src/pcm8_rate_converter.sv
// Top level of the 8-bit PCM rate converter: configuration registers and
// the front, queue and back parts. Depends on p8rc_pkg and all p8rc_ modules.
//
// Usage. Unsigned 8-bit samples arrive on the input channel (i_valid,
// o_stall, i_sample_in, i_last_in); a transfer takes place on a clock edge
// with i_valid high and o_stall low. Signed 8-bit results leave on the output
// channel (o_valid, i_stall, o_sample_out, o_last_out) under the same rule.
// o_last_out marks the final result of a clip. The user writes the
// three registers (step ratio, its reciprocal, alignment) through
// i_cfg_we, i_cfg_index and i_cfg_data only while the block is idle;
// the block itself does not enforce this.
// Sequence. A sample that closes no window passes the idle, window-step,
// finish and done states of the back-end sequencer. A window that closes
// exactly at the end of a sample adds the window-sum multiply, then clamp
// and rounding; one that closes inside a sample adds these and another
// window step for the rest of the sample. In repeat mode each repeated
// result takes its own repeat step. The final sample of a clip adds a
// padding setup step, and each padding sample waits for the bit-serial
// divider that scales the ramp. A two-entry queue lets the next samples
// transfer in while the back part works.
//
// Reset restores the register defaults (ratio 1.0, no padding) and clears
// all clip state. When the receiver stalls, one result waits in the output
// register and one in the hold stage; the sequencer then pauses.
module pcm8_rate_converter #(
    parameter int MAX_ALIGN    = p8rc_pkg::DEF_MAX_ALIGN,
    parameter int MAX_UPSAMPLE = p8rc_pkg::DEF_MAX_UPSAMPLE
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [p8rc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [p8rc_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [p8rc_pkg::SAMPLE_W-1:0]         i_sample_in,
    input  logic                                  i_last_in,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [p8rc_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic                                  o_last_out
);
    import p8rc_pkg::*;

    t_cfg  r_cfg;
    t_item front_item;
    t_item queue_item;
    logic  push;
    logic  pop;
    logic  queue_full;
    logic  queue_empty;

    // Register writes to an index outside the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_ratio <= DEF_STEP_RATIO;
            r_cfg.step_recip <= DEF_STEP_RECIP;
            r_cfg.align      <= DEF_ALIGN;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_STEP_RATIO: r_cfg.step_ratio <= i_cfg_data[STEP_W-1:0];
                REG_STEP_RECIP: r_cfg.step_recip <= i_cfg_data[RECIP_W-1:0];
                REG_ALIGN:      r_cfg.align      <= i_cfg_data[ALIGN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The front part removes the bias and tags each sample with its mode.
    p8rc_front #(
        .MAX_ALIGN (MAX_ALIGN)
    ) u_front (
        .i_valid     (i_valid),
        .i_sample_in (i_sample_in),
        .i_last_in   (i_last_in),
        .i_cfg       (r_cfg),
        .i_full      (queue_full),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_item      (front_item)
    );

    p8rc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_empty (queue_empty)
    );

    // The back part owns all clip state and the output channel.
    p8rc_back #(
        .MAX_ALIGN    (MAX_ALIGN),
        .MAX_UPSAMPLE (MAX_UPSAMPLE)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_empty      (queue_empty),
        .i_item       (queue_item),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_sample_out (o_sample_out),
        .o_last_out   (o_last_out)
    );

endmodule

FILE: src/p8rc_divider.sv
// Restoring divider, one quotient bit per cycle, for the padding ramp.
// Depends on nothing but its parameters.
module p8rc_divider #(
    parameter int NUM_W = 13,
    parameter int DEN_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CW = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quot;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb begin
        trial = {r_rem, r_quot[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(NUM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= '0;
            r_rem  <= '0;
            r_den  <= i_den;
            r_quot <= i_num;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + CW'(1);
            r_rem  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quot <= {r_quot[NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: src/p8rc_queue.sv
// Short FIFO of classified samples between the front and back parts.
// Depends on p8rc_pkg for the item type and the queue depth.
module p8rc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  p8rc_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output p8rc_pkg::t_item o_item,
    output logic            o_empty
);
    import p8rc_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;

    always_comb begin
        n_wr = (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PW'(1);
        n_rd = (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rd];
    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

endmodule

FILE: src/p8rc_front.sv
// Front part: takes input transfers, removes the PCM bias and tags each
// sample with its processing mode and padding setup. Depends on p8rc_pkg.
module p8rc_front #(
    parameter int MAX_ALIGN = p8rc_pkg::DEF_MAX_ALIGN
) (
    input  logic                           i_valid,
    input  logic [p8rc_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                           i_last_in,
    input  p8rc_pkg::t_cfg                 i_cfg,
    input  logic                           i_full,
    output logic                           o_stall,
    output logic                           o_push,
    output p8rc_pkg::t_item                o_item
);
    import p8rc_pkg::*;

    localparam logic [ALIGN_W-1:0] MAX_A = ALIGN_W'(MAX_ALIGN);

    logic [ALIGN_W-1:0] align_sat;

    always_comb begin
        align_sat = (i_cfg.align > MAX_A) ? MAX_A : i_cfg.align;

        o_item.sample = $signed(i_sample_in ^ SAMPLE_BIAS);
        o_item.last   = i_last_in;
        o_item.avg    = i_cfg.step_ratio >= STEP_W'(Q_ONE);
        o_item.pad_en = align_sat > ALIGN_W'(1);
        o_item.pad_a  = align_sat;
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule

FILE: src/p8rc_back.sv
// Back part: window averaging, sample repetition and end-of-clip padding,
// with a one-result hold stage and the output register. Depends on
// p8rc_pkg and p8rc_divider.
module p8rc_back #(
    parameter int MAX_ALIGN    = p8rc_pkg::DEF_MAX_ALIGN,
    parameter int MAX_UPSAMPLE = p8rc_pkg::DEF_MAX_UPSAMPLE
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  p8rc_pkg::t_cfg                        i_cfg,
    input  logic                                  i_empty,
    input  p8rc_pkg::t_item                       i_item,
    output logic                                  o_pop,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [p8rc_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic                                  o_last_out
);
    import p8rc_pkg::*;

    localparam int AW  = (MAX_ALIGN > 2) ? $clog2(MAX_ALIGN) : 1;
    localparam int BW  = $clog2(MAX_UPSAMPLE + 1);
    localparam int Y_W = LV_W + AW + 1;
    localparam int QW  = Y_W - FRAC_BITS - 1;
    localparam int WP_W = SAMPLE_W + BUDGET_W + 1;

    // Sequencer and clip state.
    t_state                     r_state,  n_state;
    t_ret                       r_ret,    n_ret;
    logic [PHASE_W-1:0]         r_phase,  n_phase;
    logic signed [SUM_W-1:0]    r_sum,    n_sum;
    logic                       r_open,   n_open;
    logic signed [LV_W-1:0]     r_lv,     n_lv;
    logic [CNT_W-1:0]           r_cnt,    n_cnt;

    // Current item.
    logic signed [SAMPLE_W-1:0] r_s,      n_s;
    logic                       r_last,   n_last;
    logic                       r_avg,    n_avg;
    logic                       r_pad_en, n_pad_en;
    logic [ALIGN_W-1:0]         r_pad_a,  n_pad_a;
    logic [BUDGET_W-1:0]        r_budget, n_budget;
    logic [BW-1:0]              r_burst,  n_burst;
    logic signed [PROD_W-1:0]   r_prod,   n_prod;
    logic [AW-1:0]              r_size,   n_size;
    logic [AW-1:0]              r_k,      n_k;

    // Hold stage and output register.
    logic                       r_pend_valid, n_pend_valid;
    logic [SAMPLE_W-1:0]        r_pend_sample, n_pend_sample;
    logic                       r_out_valid,  n_out_valid;
    logic [SAMPLE_W-1:0]        r_out_sample, n_out_sample;
    logic                       r_out_last,   n_out_last;

    logic                       out_free;
    logic                       can_put;
    logic                       do_put;
    logic                       do_release;
    logic [SAMPLE_W-1:0]        put_val;

    logic [PHASE_W-1:0]         phase_eff;
    logic signed [SUM_W-1:0]    sum_eff;
    logic                       fits;
    logic [BUDGET_W-1:0]        weight;
    logic signed [WP_W-1:0]     wprod;
    logic signed [SUM_W-1:0]    acc;
    logic [PHASE_W-1:0]         phase_left;

    logic signed [PROD_W-1:0]   p_clamp;
    logic                       p_neg;
    logic [PROD_W-1:0]          p_mag;
    logic [PROD_W-1:0]          lv_round;
    logic [PROD_W-1:0]          samp_round;
    logic [LV_W-1:0]            lv_val;
    logic [SAMPLE_W-1:0]        samp_val;

    logic                       rep_go;
    logic [ALIGN_W-1:0]         pad_mask;
    logic [ALIGN_W-1:0]         pad_size;
    logic [LV_W-1:0]            lv_mag;
    logic [LV_W+AW-1:0]         pad_prod;
    logic [Y_W-1:0]             pad_y;
    logic [SAMPLE_W-1:0]        pad_q;
    logic [SAMPLE_W-1:0]        pad_val;

    logic                       div_start;
    logic [QW-1:0]              div_num;
    logic                       div_done;
    logic [QW-1:0]              div_quot;

    p8rc_divider #(
        .NUM_W (QW),
        .DEN_W (AW)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_size),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Datapath terms used by the sequencer.
    always_comb begin
        out_free = !r_out_valid || !i_stall;
        can_put  = !r_pend_valid || out_free;

        phase_eff  = r_open ? r_phase : PHASE_W'(i_cfg.step_ratio);
        sum_eff    = r_open ? r_sum : '0;
        fits       = phase_eff >= PHASE_W'(r_budget);
        weight     = fits ? r_budget : phase_eff[BUDGET_W-1:0];
        wprod      = r_s * $signed({1'b0, weight});
        acc        = sum_eff + SUM_W'(wprod);
        phase_left = phase_eff - PHASE_W'(r_budget);

        if (r_prod > P_HI) begin
            p_clamp = P_HI;
        end else if (r_prod < P_LO) begin
            p_clamp = P_LO;
        end else begin
            p_clamp = r_prod;
        end
        p_neg      = p_clamp[PROD_W-1];
        p_mag      = p_neg ? unsigned'(-p_clamp) : unsigned'(p_clamp);
        lv_round   = (p_mag + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        samp_round = (p_mag + (PROD_W'(1) << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
        lv_val     = p_neg ? -lv_round[LV_W-1:0] : lv_round[LV_W-1:0];
        samp_val   = p_neg ? -samp_round[SAMPLE_W-1:0] : samp_round[SAMPLE_W-1:0];

        rep_go = (r_phase < PHASE_W'(Q_ONE)) && (r_burst < BW'(MAX_UPSAMPLE));

        pad_mask = r_pad_a - ALIGN_W'(1);
        pad_size = r_pad_a - ALIGN_W'(r_cnt & pad_mask[CNT_W-1:0]);

        lv_mag   = r_lv[LV_W-1] ? unsigned'(-r_lv) : unsigned'(r_lv);
        pad_prod = lv_mag * r_k;
        pad_y    = {pad_prod, 1'b0} + (Y_W'(r_size) << FRAC_BITS);
        div_num  = pad_y[Y_W-1:FRAC_BITS+1];

        pad_q   = div_quot[SAMPLE_W-1:0];
        pad_val = r_lv[LV_W-1] ? -pad_q : pad_q;
    end

    // Sequencer: next state and next register values.
    always_comb begin
        n_state       = r_state;
        n_ret         = r_ret;
        n_phase       = r_phase;
        n_sum         = r_sum;
        n_open        = r_open;
        n_lv          = r_lv;
        n_cnt         = r_cnt;
        n_s           = r_s;
        n_last        = r_last;
        n_avg         = r_avg;
        n_pad_en      = r_pad_en;
        n_pad_a       = r_pad_a;
        n_budget      = r_budget;
        n_burst       = r_burst;
        n_prod        = r_prod;
        n_size        = r_size;
        n_k           = r_k;
        n_pend_valid  = r_pend_valid;
        n_pend_sample = r_pend_sample;
        n_out_valid   = r_out_valid && i_stall;
        n_out_sample  = r_out_sample;
        n_out_last    = r_out_last;
        o_pop         = 1'b0;
        do_put        = 1'b0;
        do_release    = 1'b0;
        put_val       = '0;
        div_start     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop    = 1'b1;
                    n_s      = i_item.sample;
                    n_last   = i_item.last;
                    n_avg    = i_item.avg;
                    n_pad_en = i_item.pad_en;
                    n_pad_a  = i_item.pad_a;
                    n_budget = Q_ONE;
                    n_burst  = '0;
                    n_state  = i_item.avg ? ST_AVG : ST_REP;
                end
            end
            ST_AVG: begin
                // One window step: the sample either fills what is left of
                // its unit width, or closes the window and keeps the rest.
                n_open = 1'b1;
                n_sum  = acc;
                if (fits) begin
                    n_phase = phase_left;
                    if (phase_left == '0) begin
                        n_ret   = RET_FINISH;
                        n_state = ST_MUL;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end else begin
                    n_budget = r_budget - phase_eff[BUDGET_W-1:0];
                    n_phase  = '0;
                    n_ret    = RET_AVG;
                    n_state  = ST_MUL;
                end
            end
            ST_MUL: begin
                n_prod  = r_sum * $signed({1'b0, i_cfg.step_recip});
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (can_put) begin
                    do_put  = 1'b1;
                    put_val = samp_val;
                    n_lv    = $signed(lv_val);
                    n_sum   = '0;
                    n_open  = 1'b0;
                    unique case (r_ret)
                        RET_AVG:    n_state = ST_AVG;
                        RET_FINISH: n_state = ST_FINISH;
                        RET_PAD:    n_state = ST_PAD_SETUP;
                        default:    n_state = ST_FINISH;
                    endcase
                end
            end
            ST_REP: begin
                if (rep_go) begin
                    if (can_put) begin
                        do_put  = 1'b1;
                        put_val = r_s;
                        n_lv    = $signed(LV_W'({r_s, {FRAC_BITS{1'b0}}}));
                        n_phase = r_phase + PHASE_W'(i_cfg.step_ratio);
                        n_burst = r_burst + BW'(1);
                    end
                end else begin
                    // A burst cut by the limit drops the rest of its phase.
                    n_phase = (r_phase >= PHASE_W'(Q_ONE)) ?
                              r_phase - PHASE_W'(Q_ONE) : '0;
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_last) begin
                    n_state = ST_DONE;
                end else if (r_avg && r_open) begin
                    n_ret   = RET_PAD;
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_PAD_SETUP;
                end
            end
            ST_PAD_SETUP: begin
                if (r_pad_en && pad_size != r_pad_a) begin
                    n_size  = pad_size[AW-1:0];
                    n_k     = AW'(pad_size - ALIGN_W'(1));
                    n_state = ST_PAD_MUL;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_PAD_MUL: begin
                div_start = 1'b1;
                n_state   = ST_PAD_DIV;
            end
            ST_PAD_DIV: begin
                if (div_done) begin
                    n_state = ST_PAD_PUT;
                end
            end
            ST_PAD_PUT: begin
                if (can_put) begin
                    do_put  = 1'b1;
                    put_val = pad_val;
                    if (r_k == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_k     = r_k - AW'(1);
                        n_state = ST_PAD_MUL;
                    end
                end
            end
            ST_DONE: begin
                if (!r_pend_valid || out_free) begin
                    do_release = r_pend_valid;
                    n_state    = ST_IDLE;
                    if (r_last) begin
                        n_phase = '0;
                        n_sum   = '0;
                        n_open  = 1'b0;
                        n_lv    = '0;
                        n_cnt   = '0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A new result pushes the held one out; it cannot be the last.
        if (do_put) begin
            if (r_pend_valid) begin
                n_out_valid  = 1'b1;
                n_out_sample = r_pend_sample;
                n_out_last   = 1'b0;
            end
            n_pend_valid  = 1'b1;
            n_pend_sample = put_val;
            n_cnt         = r_cnt + CNT_W'(1);
        end
        if (do_release) begin
            n_out_valid  = 1'b1;
            n_out_sample = r_pend_sample;
            n_out_last   = r_last;
            n_pend_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ret        <= RET_FINISH;
            r_phase      <= '0;
            r_sum        <= '0;
            r_open       <= 1'b0;
            r_lv         <= '0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ret        <= n_ret;
            r_phase      <= n_phase;
            r_sum        <= n_sum;
            r_open       <= n_open;
            r_lv         <= n_lv;
            r_cnt        <= n_cnt;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s           <= n_s;
        r_last        <= n_last;
        r_avg         <= n_avg;
        r_pad_en      <= n_pad_en;
        r_pad_a       <= n_pad_a;
        r_budget      <= n_budget;
        r_burst       <= n_burst;
        r_prod        <= n_prod;
        r_size        <= n_size;
        r_k           <= n_k;
        r_pend_sample <= n_pend_sample;
        r_out_sample  <= n_out_sample;
        r_out_last    <= n_out_last;
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = $signed(r_out_sample);
    assign o_last_out   = r_out_last;

endmodule

FILE: tb/pcm8_rate_converter_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for pcm8_rate_converter: directed table, then random clips.
// A built-in predictor of the resampler computes the expected results.
// Depends on p8rc_pkg and the converter RTL only.

module pcm8_rate_converter_test;
    import p8rc_pkg::*;

    localparam int CLK_PERIOD       = 8;
    localparam int RESET_CYCLES     = 10;
    localparam int LIMIT_CYCLES     = 1_500_000;
    // Items that close no window may still be in flight once every expected
    // result has arrived: two queue entries plus one in the sequencer.
    localparam int SETTLE_CYCLES    = 64;
    localparam int HOLD_CYCLES      = 400;
    localparam int RANDOM_PER_PHASE = 102;
    localparam int RESULT_CAP       = 64;
    localparam int MAX_REPORTS      = 10;
    localparam int DIRECTED_ROWS    = 31;

    localparam longint Q_UNIT   = 64'sd1 << FRAC_BITS;
    localparam longint PROD_MAX = 64'sd127 << (2 * FRAC_BITS);
    localparam longint PROD_MIN = -(64'sd128 << (2 * FRAC_BITS));

    // One output transfer as the converter should produce it.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] smp;
        logic                       lst;
    } t_pcm_out;

    // Directed table: a register load, a sample checked by the predictor, or
    // a sample whose single result is written out in the table itself.
    typedef enum logic [1:0] {
        ROW_REGS,
        ROW_SAMPLE,
        ROW_FIXED
    } t_row_kind;

    typedef struct packed {
        t_row_kind                  kind;
        logic [STEP_W-1:0]          step;
        logic [RECIP_W-1:0]         recip;
        logic [ALIGN_W-1:0]         align;
        logic [SAMPLE_W-1:0]        smp;
        logic                       lst;
        logic signed [SAMPLE_W-1:0] want_smp;
        logic                       want_lst;
    } t_row;

    t_row directed_plan [DIRECTED_ROWS] = '{
        // Reset defaults: ratio 1.0, so each result is the sample minus 0x80.
        '{ROW_FIXED,  0,       0,      0,  8'h00, 1'b0, -128, 1'b0},
        '{ROW_FIXED,  0,       0,      0,  8'hFF, 1'b0,  127, 1'b0},
        '{ROW_FIXED,  0,       0,      0,  8'h80, 1'b1,    0, 1'b1},
        '{ROW_FIXED,  0,       0,      0,  8'h7F, 1'b1,   -1, 1'b1},
        // Ratio 2.5: fractional window edges, partial window, ramp to 8.
        '{ROW_REGS,   163840,  26214,  8,  8'h00, 1'b0,    0, 1'b0},
        '{ROW_SAMPLE, 0,       0,      0,  8'hFF, 1'b0,    0, 1'b0},
        '{ROW_SAMPLE, 0,       0,      0,  8'h00, 1'b0,    0, 1'b0},
        '{ROW_SAMPLE, 0,       0,      0,  8'hC3, 1'b0,    0, 1'b0},
        '{ROW_SAMPLE, 0,       0,      0,  8'h3C, 1'b1,    0, 1'b0},
        // Ratio 1/32: full repeat bursts; alignment 63 saturates to 32.
        '{ROW_REGS,   2048,    65536,  63, 8'h00, 1'b0,    0, 1'b0},
        '{ROW_SAMPLE, 0,       0,      0,  8'h01, 1'b0,    0, 1'b0},
        '{ROW_SAMPLE, 0,       0,      0,  8'hE0, 1'b0,    0, 1'b0},
        // Rate changed in the middle of the clip, back to averaging.
        '{ROW_REGS,   98304,   43691,  63, 8'h00, 1'b0,    0, 1'b0},
        '{ROW_SAMPLE, 0,       0,      0,  8'h90, 1'b1,    0, 1'b0},
        // Largest ratio, smallest reciprocal, alignment not a power of two.
        '{ROW_REGS,   2097151, 2048,   6,  8'h00, 1'b0,    0, 1'b0},
        '{ROW_SAMPLE, 0,       0,      0,  8'h00, 1'b0,    0, 1'b0},
        '{ROW_SAMPLE, 0,       0,      0,  8'hFF, 1'b0,    0, 1'b0},
        '{ROW_SAMPLE, 0,       0,      0,  8'h40, 1'b1,    0, 1'b0},
        // Burst cut by the repeat limit, padding off.
        '{ROW_REGS,   2000,    65536,  0,  8'h00, 1'b0,    0, 1'b0},
        '{ROW_SAMPLE, 0,       0,      0,  8'h80, 1'b0,    0, 1'b0},
        '{ROW_SAMPLE, 0,       0,      0,  8'h81, 1'b1,    0, 1'b0},
        // Ratio 2.0: window edges fall on sample edges.
        '{ROW_REGS,   131072,  32768,  4,  8'h00, 1'b0,    0, 1'b0},
        '{ROW_SAMPLE, 0,       0,      0,  8'h10, 1'b0,    0, 1'b0},
        '{ROW_SAMPLE, 0,       0,      0,  8'h20, 1'b0,    0, 1'b0},
        '{ROW_SAMPLE, 0,       0,      0,  8'h30, 1'b0,    0, 1'b0},
        '{ROW_SAMPLE, 0,       0,      0,  8'h40, 1'b0,    0, 1'b0},
        '{ROW_SAMPLE, 0,       0,      0,  8'h50, 1'b1,    0, 1'b0},
        // Ratio 16 leaves a long open window; switching to ratio 0.5 makes the
        // last sample of the clip produce nothing at all.
        '{ROW_REGS,   1048576, 131071, 1,  8'h00, 1'b0,    0, 1'b0},
        '{ROW_SAMPLE, 0,       0,      0,  8'h00, 1'b0,    0, 1'b0},
        '{ROW_REGS,   32768,   65536,  1,  8'h00, 1'b0,    0, 1'b0},
        '{ROW_SAMPLE, 0,       0,      0,  8'hFF, 1'b1,    0, 1'b0}
    };

    // Block ports; every input has a known value from time zero.
    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = REG_STEP_RATIO;
    logic [CFG_W-1:0]           i_cfg_data  = '0;
    logic                       i_valid     = 1'b0;
    logic [SAMPLE_W-1:0]        i_sample_in = '0;
    logic                       i_last_in   = 1'b0;
    logic                       i_stall     = 1'b0;
    logic                       o_stall;
    logic                       o_valid;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic                       o_last_out;

    // Predictor copy of the registers, at their reset values.
    logic [STEP_W-1:0]  rate_step  = DEF_STEP_RATIO;
    logic [RECIP_W-1:0] rate_recip = DEF_STEP_RECIP;
    logic [ALIGN_W-1:0] rate_align = DEF_ALIGN;

    // Predictor copy of the clip state.
    longint     box_phase  = 0;
    longint     box_sum    = 0;
    bit         box_open   = 1'b0;
    longint     held_value = 0;
    logic [4:0] out_count  = '0;

    t_pcm_out step_results[$];
    t_pcm_out pending_out[$];

    int gap_pct      = 0;
    int stall_pct    = 0;
    bit hold_request = 1'b0;
    int hold_left    = 0;

    int cycle_count   = 0;
    int fail_count    = 0;
    int samples_sent  = 0;
    int results_seen  = 0;
    int reg_writes    = 0;
    int clips_sent    = 0;

    pcm8_rate_converter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample_in  (i_sample_in),
        .i_last_in    (i_last_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_sample_out (o_sample_out),
        .o_last_out   (o_last_out)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic longint round_half_away(longint v, int sh);
        longint mag;
        mag = (v < 0) ? -v : v;
        if (sh > 0) begin
            mag = (mag + (64'sd1 << (sh - 1))) >>> sh;
        end
        return (v < 0) ? -mag : mag;
    endfunction

    // Every result counts toward the clip length, which sets the padding.
    function automatic void push_result(longint v);
        t_pcm_out res;
        if (step_results.size() >= RESULT_CAP) begin
            return;
        end
        res.smp = v[SAMPLE_W-1:0];
        res.lst = 1'b0;
        step_results.push_back(res);
        out_count = out_count + 5'd1;
    endfunction

    // Scale the box sum by the reciprocal, clamp to the 8-bit range, round
    // the result to an integer and keep a Q16 copy for the padding ramp.
    function automatic void close_window();
        longint prod;
        prod = box_sum * longint'(rate_recip);
        if (prod > PROD_MAX) begin
            prod = PROD_MAX;
        end
        if (prod < PROD_MIN) begin
            prod = PROD_MIN;
        end
        held_value = round_half_away(prod, FRAC_BITS);
        push_result(round_half_away(prod, 2 * FRAC_BITS));
        box_sum  = 0;
        box_open = 1'b0;
    endfunction

    // Expected results of one input sample, left in step_results.
    function automatic void convert_sample(logic [SAMPLE_W-1:0] smp, logic lst);
        longint s;
        longint budget;
        longint pos;
        longint num;
        longint mag;
        longint denom;
        int     burst;
        int     a;
        int     pad_len;
        bit     averaging;
        bit     consumed;

        step_results.delete();
        s = longint'(smp) - longint'(SAMPLE_BIAS);
        averaging = (longint'(rate_step) >= Q_UNIT);

        if (averaging) begin
            // Spread one sample's unit width over the open window and as
            // many following windows as it covers.
            budget   = Q_UNIT;
            consumed = 1'b0;
            while (!consumed) begin
                if (!box_open) begin
                    box_open  = 1'b1;
                    box_phase = longint'(rate_step);
                    box_sum   = 0;
                end
                if (box_phase >= budget) begin
                    box_sum   += s * budget;
                    box_phase -= budget;
                    if (box_phase == 0) begin
                        close_window();
                    end
                    consumed = 1'b1;
                end else begin
                    box_sum   += s * box_phase;
                    budget    -= box_phase;
                    box_phase  = 0;
                    close_window();
                end
            end
        end else begin
            // Repeat the sample for each output position inside it, up to
            // the burst limit; a cut burst drops the rest of the phase.
            pos   = box_phase;
            burst = 0;
            while (pos < Q_UNIT && burst < DEF_MAX_UPSAMPLE) begin
                push_result(s);
                held_value = s * Q_UNIT;
                pos += longint'(rate_step);
                burst++;
            end
            box_phase = ((pos >= Q_UNIT) ? pos - Q_UNIT : 0) & 64'h3F_FFFF;
        end

        if (lst) begin
            if (averaging && box_open) begin
                close_window();
            end
            a = (int'(rate_align) > DEF_MAX_ALIGN) ? DEF_MAX_ALIGN : int'(rate_align);
            if (a > 1) begin
                pad_len = a - (int'(out_count) & (a - 1));
                if (pad_len != a) begin
                    denom = longint'(pad_len) << FRAC_BITS;
                    for (int i = 0; i < pad_len; i++) begin
                        num = held_value * longint'(pad_len - 1 - i);
                        mag = (num < 0) ? -num : num;
                        mag = (2 * mag + denom) / (2 * denom);
                        push_result((num < 0) ? -mag : mag);
                    end
                end
            end
            if (step_results.size() != 0) begin
                step_results[step_results.size() - 1].lst = 1'b1;
            end
            box_phase  = 0;
            box_sum    = 0;
            box_open   = 1'b0;
            held_value = 0;
            out_count  = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one sample and hold it until the transfer. The expectation is
    // queued at the transfer edge, before any result of it can appear. A
    // fixed row replaces the predicted results with its own.
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic lst,
                               input bit fixed, input t_pcm_out fixed_res);
        i_valid     <= 1'b1;
        i_sample_in <= smp;
        i_last_in   <= lst;
        do @(posedge i_clk); while (o_stall);
        convert_sample(smp, lst);
        if (fixed) begin
            pending_out.push_back(fixed_res);
        end else begin
            foreach (step_results[k]) begin
                pending_out.push_back(step_results[k]);
            end
        end
        samples_sent++;
        if (lst) begin
            clips_sent++;
        end
        if ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
    endtask

    // Stop offering and wait for every expected result, then give samples
    // that close no window time to leave the block.
    task automatic settle_idle();
        i_valid <= 1'b0;
        while (pending_out.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all three registers, one per clock, and mirror them.
    task automatic load_rates(input logic [STEP_W-1:0] step,
                              input logic [RECIP_W-1:0] recip,
                              input logic [ALIGN_W-1:0] align);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_STEP_RATIO;
        i_cfg_data  <= CFG_W'(step);
        @(posedge i_clk);
        rate_step    = step;
        i_cfg_index <= REG_STEP_RECIP;
        i_cfg_data  <= CFG_W'(recip);
        @(posedge i_clk);
        rate_recip   = recip;
        i_cfg_index <= REG_ALIGN;
        i_cfg_data  <= CFG_W'(align);
        @(posedge i_clk);
        rate_align   = align;
        i_cfg_we    <= 1'b0;
        reg_writes  += 3;
    endtask

    // Mostly moderate ratios in both modes, with the far ends, mismatched
    // reciprocals (which drive the clamp) and every kind of alignment.
    task automatic load_random_rates();
        logic [STEP_W-1:0]  step;
        logic [RECIP_W-1:0] recip;
        logic [ALIGN_W-1:0] align;
        case ($urandom_range(9))
            0, 1, 2, 3: step = STEP_W'($urandom_range(65536, 327680));
            4:          step = STEP_W'($urandom_range(327681, 2097151));
            5, 6, 7:    step = STEP_W'($urandom_range(8192, 65535));
            8:          step = STEP_W'($urandom_range(0, 8191));
            default:    step = STEP_W'(65536);
        endcase
        if ($urandom_range(7) == 0) begin
            recip = RECIP_W'($urandom_range(0, 131071));
        end else if (step >= STEP_W'(65536)) begin
            recip = RECIP_W'(((64'd1 << 32) + step / 2) / step);
        end else begin
            recip = RECIP_W'(65536);
        end
        case ($urandom_range(7))
            0:          align = ALIGN_W'(0);
            1:          align = ALIGN_W'(1);
            6:          align = ALIGN_W'($urandom_range(0, 63));
            7:          align = ALIGN_W'(32);
            default:    align = ALIGN_W'(1 << $urandom_range(1, 5));
        endcase
        load_rates(step, recip, align);
    endtask

    function automatic logic [SAMPLE_W-1:0] draw_pcm();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return SAMPLE_W'($urandom_range(255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: checks each result transfer against the oldest
    // expectation and drives the stall, either at random or, on request,
    // as one long hold counted here.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pcm_out want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            results_seen++;
            if (pending_out.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("unexpected result %0d: sample %0d last %0b",
                             results_seen, o_sample_out, o_last_out);
                end
            end else begin
                want = pending_out.pop_front();
                if (o_sample_out !== want.smp || o_last_out !== want.lst) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("result %0d: expected sample %0d last %0b, got sample %0d last %0b",
                                 results_seen, want.smp, want.lst, o_sample_out, o_last_out);
                    end
                end
            end
        end
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Run limit, well above the slowest correct run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("no progress: run stopped after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        t_pcm_out fixed_res;
        int       clip_len;
        int       cut_at;
        int       phase_items;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, no idling on either side. The first rows run
        // on the reset register values.
        fixed_res = '0;
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            case (directed_plan[r].kind)
                ROW_REGS: begin
                    settle_idle();
                    load_rates(directed_plan[r].step, directed_plan[r].recip,
                               directed_plan[r].align);
                end
                ROW_FIXED: begin
                    fixed_res.smp = directed_plan[r].want_smp;
                    fixed_res.lst = directed_plan[r].want_lst;
                    send_sample(directed_plan[r].smp, directed_plan[r].lst, 1'b1, fixed_res);
                end
                default: begin
                    send_sample(directed_plan[r].smp, directed_plan[r].lst, 1'b0, fixed_res);
                end
            endcase
        end

        // Random clips in four handshake phases: none idle, sender idle half
        // the time, receiver stalling half the time, and both at 27 percent.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 50; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 50; end
                default: begin gap_pct = 27; stall_pct = 27; end
            endcase
            phase_items = 0;
            while (phase_items < RANDOM_PER_PHASE) begin
                settle_idle();
                if (phase_items == 0 && (ph == 0 || ph == 3)) begin
                    // Long receiver hold while samples keep coming: the
                    // output stages and the queue fill and the input stalls.
                    load_rates(STEP_W'(65536), RECIP_W'(65536), ALIGN_W'(16));
                    hold_request = 1'b1;
                    clip_len = 40;
                    cut_at   = 0;
                end else begin
                    load_random_rates();
                    clip_len = ($urandom_range(7) == 0) ? $urandom_range(25, 60)
                                                         : $urandom_range(1, 12);
                    // Now and then the rates change in the middle of a clip.
                    cut_at = (clip_len > 1 && $urandom_range(9) == 0)
                             ? $urandom_range(1, clip_len - 1) : 0;
                end
                for (int k = 0; k < clip_len; k++) begin
                    if (cut_at != 0 && k == cut_at) begin
                        settle_idle();
                        load_random_rates();
                    end
                    send_sample(draw_pcm(), k == clip_len - 1, 1'b0, fixed_res);
                end
                phase_items += clip_len;
            end
        end

        settle_idle();
        if (pending_out.size() != 0) begin
            fail_count += pending_out.size();
            $display("%0d expected results never arrived", pending_out.size());
        end
        $display("covered %0d samples in %0d clips, %0d results, %0d register writes",
                 samples_sent, clips_sent, results_seen, reg_writes);
        $display("both rate modes, padding ramps, four handshake phases; %0d mismatches",
                 fail_count);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/p8rc_pkg.sv
src/p8rc_divider.sv
src/p8rc_queue.sv
src/p8rc_front.sv
src/p8rc_back.sv
src/pcm8_rate_converter.sv
tb/pcm8_rate_converter_test.sv
